// File: rtl/a85_pkg.sv
// Shared types and constants for the ASCII85 stream encoder.
// No dependencies; every other file in rtl but a85_fifo imports this package.
package a85_pkg;

  localparam int COL_W = 7;   // column counter, holds LINE_LIMIT + 4 for any limit up to 123
  localparam int DIG_W = 7;   // one base-85 digit, 0..84

  localparam logic [6:0]  BASE    = 7'd85;
  localparam logic [12:0] BASE_SQ = 13'd7225;

  // floor(2^44 / 7225): quotient estimate is exact or one short.
  localparam logic [31:0] RECIP_SQ = 32'd2434904642;
  // ceil(2^20 / 85): exact quotient for any value below 7225.
  localparam logic [13:0] RECIP_85 = 14'd12337;

  localparam logic [7:0] CHAR_BANG  = 8'd33;
  localparam logic [7:0] CHAR_Z     = 8'd122;
  localparam logic [7:0] CHAR_TILDE = 8'd126;
  localparam logic [7:0] CHAR_GT    = 8'd62;
  localparam logic [7:0] CHAR_NL    = 8'd10;

  // What the emitter does with one job besides its digits.
  typedef struct packed {
    logic       zero;   // all-zero full group: emit 'z' instead of digits
    logic       nl;     // newline after the group
    logic       fin;    // terminator follows
    logic [2:0] ndig;   // digits to emit: 5 for a group, n+1 for a tail
  } meta_t;

  typedef struct packed {
    logic [31:0] word;
    meta_t       meta;
  } job_t;

  typedef struct packed {
    logic [4:0][DIG_W-1:0] digs;  // digs[0] is the most significant digit
    meta_t                 meta;
  } conv_t;

endpackage

// File: rtl/a85_front.sv
// Front end: gathers bytes into groups, tracks the output column and
// builds one job per group or final byte. Depends on a85_pkg.
module a85_front #(
  parameter int LINE_LIMIT = 75
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic [7:0]      data_byte,
  input  logic            end_of_data,
  output logic            job_push,
  output a85_pkg::job_t   job
);
  import a85_pkg::*;

  logic [23:0]      group_bytes;
  logic [1:0]       group_count;
  logic [COL_W-1:0] column;

  logic [23:0]      group_bytes_next;
  logic [1:0]       group_count_next;
  logic [COL_W-1:0] column_next;

  logic             closes;
  logic [31:0]      word_full;
  logic             word_zero;
  logic [COL_W-1:0] col_sum;
  logic             need_nl;
  logic [1:0]       tail_n;
  logic [31:0]      word_tail;

  always_comb begin
    closes    = (group_count == 2'd3);
    word_full = {group_bytes, data_byte};
    word_zero = (word_full == 32'd0);
    col_sum   = column + (word_zero ? COL_W'(1) : COL_W'(5));
    need_nl   = closes && (col_sum >= COL_W'(LINE_LIMIT));
    tail_n    = group_count + 2'd1;
    group_bytes_next = {group_bytes[15:0], data_byte};

    case (tail_n)
      2'd1:    word_tail = {group_bytes_next[7:0], 24'd0};
      2'd2:    word_tail = {group_bytes_next[15:0], 16'd0};
      default: word_tail = {group_bytes_next, 8'd0};
    endcase

    group_count_next = tail_n;
    column_next      = column;
    if (closes) begin
      group_bytes_next = 24'd0;
      group_count_next = 2'd0;
      column_next      = need_nl ? '0 : col_sum;
    end
    if (end_of_data) begin
      group_bytes_next = 24'd0;
      group_count_next = 2'd0;
      column_next      = '0;
    end

    job_push       = in_fire && (closes || end_of_data);
    job.word       = closes ? word_full : word_tail;
    job.meta.zero  = closes && word_zero;
    job.meta.nl    = need_nl;
    job.meta.fin   = end_of_data;
    job.meta.ndig  = closes ? 3'd5 : ({1'b0, tail_n} + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bytes <= 24'd0;
      group_count <= 2'd0;
      column      <= '0;
    end else if (in_fire) begin
      group_bytes <= group_bytes_next;
      group_count <= group_count_next;
      column      <= column_next;
    end
  end

endmodule

// File: rtl/a85_fifo.sv
// Small job queue between the front end and the converter.
// Flip-flop storage, one write and one read port. Depends on nothing.
module a85_fifo #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/a85_conv.sv
// Base-85 converter: splits a 32-bit word into five digits in six steps,
// by two divisions by 85^2 and two by 85. Depends on a85_pkg.
module a85_conv (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  a85_pkg::job_t   job,
  output logic            job_ready,
  output logic            cv_valid,
  output a85_pkg::conv_t  cv,
  input  logic            cv_ready
);
  import a85_pkg::*;

  logic        busy;
  logic        done;
  logic [2:0]  step;
  logic [31:0] word;
  logic [63:0] prod_a;
  logic [26:0] prod_b;
  logic [19:0] quo;
  logic [12:0] rem_lo;
  logic [12:0] rem_hi;
  logic [4:0][DIG_W-1:0] digs;
  meta_t       meta;

  logic [31:0] mul_a;
  logic [12:0] mul_b;
  logic [19:0] s2_qe;
  logic [32:0] s2_rem;
  logic [6:0]  s4_qe;
  logic [20:0] s4_rem;
  logic [6:0]  dq_b;
  logic [12:0] dr_b;

  assign job_ready = !busy && (!done || cv_ready);
  assign cv_valid  = done;
  assign cv.digs   = digs;
  assign cv.meta   = meta;

  always_comb begin
    mul_a  = (step == 3'd1) ? word : {12'd0, quo};
    mul_b  = (step == 3'd3) ? rem_lo : rem_hi;
    s2_qe  = prod_a[63:44];
    s2_rem = {1'b0, word} - (33'(s2_qe) * 33'(BASE_SQ));
    s4_qe  = prod_a[50:44];
    s4_rem = {1'b0, quo} - (21'(s4_qe) * 21'(BASE_SQ));
    dq_b   = prod_b[26:20];
    dr_b   = (step == 3'd4) ? rem_lo : rem_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 3'd0;
    end else begin
      if (cv_ready) begin
        done <= 1'b0;
      end
      if (job_valid && job_ready) begin
        busy <= 1'b1;
        step <= 3'd1;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd6) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      word <= job.word;
      meta <= job.meta;
    end
    if (busy) begin
      case (step)
        3'd1: prod_a <= 64'(mul_a) * 64'(RECIP_SQ);
        3'd2: begin
          if (s2_rem[14:0] >= 15'(BASE_SQ)) begin
            quo    <= s2_qe + 20'd1;
            rem_lo <= 13'(s2_rem[14:0] - 15'(BASE_SQ));
          end else begin
            quo    <= s2_qe;
            rem_lo <= s2_rem[12:0];
          end
        end
        3'd3: begin
          prod_a <= 64'(mul_a) * 64'(RECIP_SQ);
          prod_b <= 27'(mul_b) * 27'(RECIP_85);
        end
        3'd4: begin
          if (s4_rem[14:0] >= 15'(BASE_SQ)) begin
            digs[0] <= s4_qe + 7'd1;
            rem_hi  <= 13'(s4_rem[14:0] - 15'(BASE_SQ));
          end else begin
            digs[0] <= s4_qe;
            rem_hi  <= s4_rem[12:0];
          end
          digs[3] <= dq_b;
          digs[4] <= 7'(dr_b - 13'(dq_b) * 13'(BASE));
        end
        3'd5: prod_b <= 27'(mul_b) * 27'(RECIP_85);
        3'd6: begin
          digs[1] <= dq_b;
          digs[2] <= 7'(dr_b - 13'(dq_b) * 13'(BASE));
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/a85_emit.sv
// Character emitter: walks one converted job out as characters through
// a registered output stage. Depends on a85_pkg.
module a85_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            cv_valid,
  input  a85_pkg::conv_t  cv,
  output logic            cv_ready,
  output logic            out_valid,
  output logic [7:0]      out_char,
  output logic            out_last,
  input  logic            out_ready
);
  import a85_pkg::*;

  localparam logic [2:0] PH_Z    = 3'd0;
  localparam logic [2:0] PH_DIG  = 3'd1;
  localparam logic [2:0] PH_NL   = 3'd2;
  localparam logic [2:0] PH_TIL  = 3'd3;
  localparam logic [2:0] PH_GT   = 3'd4;
  localparam logic [2:0] PH_END  = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;

  logic       active;
  logic [2:0] phase;
  logic [2:0] idx;
  conv_t      job;

  logic       out_free;
  logic [2:0] after_grp;
  logic [2:0] phase_next;
  logic [7:0] cur_char;

  assign cv_ready = !active;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    after_grp = job.meta.nl ? PH_NL : (job.meta.fin ? PH_TIL : PH_DONE);
    case (phase)
      PH_Z: begin
        cur_char   = CHAR_Z;
        phase_next = after_grp;
      end
      PH_DIG: begin
        cur_char   = 8'(job.digs[idx]) + CHAR_BANG;
        phase_next = (idx == job.meta.ndig - 3'd1) ? after_grp : PH_DIG;
      end
      PH_NL: begin
        cur_char   = CHAR_NL;
        phase_next = job.meta.fin ? PH_TIL : PH_DONE;
      end
      PH_TIL: begin
        cur_char   = CHAR_TILDE;
        phase_next = PH_GT;
      end
      PH_GT: begin
        cur_char   = CHAR_GT;
        phase_next = PH_END;
      end
      PH_END: begin
        cur_char   = CHAR_NL;
        phase_next = PH_DONE;
      end
      default: begin
        cur_char   = CHAR_NL;
        phase_next = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      phase     <= PH_DONE;
      idx       <= 3'd0;
    end else begin
      if (cv_valid && !active) begin
        active <= 1'b1;
        phase  <= cv.meta.zero ? PH_Z : PH_DIG;
        idx    <= 3'd0;
      end else if (active && out_free) begin
        phase <= phase_next;
        if (phase == PH_DIG) begin
          idx <= idx + 3'd1;
        end
        if (phase_next == PH_DONE) begin
          active <= 1'b0;
        end
      end
      if (out_free) begin
        out_valid <= active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cv_valid && !active) begin
      job <= cv;
    end
    if (active && out_free) begin
      out_char <= cur_char;
      out_last <= (phase_next == PH_DONE);
    end
  end

endmodule

// File: rtl/ascii85_stream_encoder_top.sv
// Top level of the ASCII85 stream encoder: front end, job queue,
// base-85 converter and character emitter. Depends on a85_pkg.
//
//   channel  dir  tdata                tlast          tuser
//   s_*      in   [7:0] data_byte      end_of_data    -
//   m_*      out  [7:0] out_char       last_of_run    -
//
// Bytes that do not close a group are taken one per cycle while the queue
// has room; they give no output. The converter takes one group or final
// byte at a time and finishes it before it takes the next. The emitter
// gives one character per cycle while m_tready is high, idle between jobs.
// Reset is synchronous, active high, and empties the queue and all stages.
// Either side may stall at any time; the queue and output register hold.
module ascii85_stream_encoder_top #(
  parameter int LINE_LIMIT  = 75,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_data
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast    // last_of_run
);
  import a85_pkg::*;

  logic  in_fire;
  logic  job_push;
  job_t  job_in;
  job_t  job_head;
  logic  q_full;
  logic  q_empty;
  logic  job_ready;
  logic  cv_valid;
  logic  cv_ready;
  conv_t cv;

  // The queue has room whenever an input is taken, so a byte never waits
  // on the converter unless the queue is full.
  assign s_tready = !q_full;
  assign in_fire  = s_tvalid && s_tready;

  a85_front #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .data_byte   (s_tdata),
    .end_of_data (s_tlast),
    .job_push    (job_push),
    .job         (job_in)
  );

  a85_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .pop   (job_ready),
    .rdata (job_head),
    .full  (q_full),
    .empty (q_empty)
  );

  a85_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!q_empty),
    .job       (job_head),
    .job_ready (job_ready),
    .cv_valid  (cv_valid),
    .cv        (cv),
    .cv_ready  (cv_ready)
  );

  a85_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cv_valid  (cv_valid),
    .cv        (cv),
    .cv_ready  (cv_ready),
    .out_valid (m_tvalid),
    .out_char  (m_tdata),
    .out_last  (m_tlast),
    .out_ready (m_tready)
  );

`ifndef SYNTHESIS
  // Every converted digit is a proper base-85 digit.
  a_digits_in_range: assert property (@(posedge clk) disable iff (rst)
    cv_valid |-> (cv.digs[0] < BASE) && (cv.digs[1] < BASE) && (cv.digs[2] < BASE)
                 && (cv.digs[3] < BASE) && (cv.digs[4] < BASE))
    else $error("converter produced a digit outside 0..84");

  // A job at the queue head asks for two to five digits.
  a_ndig_range: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (job_head.meta.ndig >= 3'd2) && (job_head.meta.ndig <= 3'd5))
    else $error("job with an illegal digit count");

  // The 'z' shortcut and the line break only belong to full groups.
  a_zero_full: assert property (@(posedge clk) disable iff (rst)
    job_push && (job_in.meta.zero || job_in.meta.nl) |-> job_in.meta.ndig == 3'd5)
    else $error("zero or newline flag on a partial group");

  // A job is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !q_full)
    else $error("job pushed into a full queue");

  // Nothing is offered in the cycle after reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

// File: tb/sv/a85_stream_checker.sv
// Scoreboard for the ASCII85 stream encoder: predicts the characters each
// accepted byte causes and compares them with the output channel.
// Depends on a85_pkg for the character constants.
module a85_stream_checker
  import a85_pkg::*;
#(
  parameter int LINE_LIMIT = 75
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic       m_tlast,
  output int         mismatches,
  output int         outstanding,
  output int         chars_checked
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } a85_char_t;

  a85_char_t   expected_chars[$];
  a85_char_t   oldest;
  logic [23:0] held_bytes = '0;
  logic [1:0]  held_count = '0;
  logic [6:0]  line_col   = '0;
  int          err_count  = 0;
  int          checked    = 0;

  // Five base-85 digits as characters; digit 0 (most significant) in [7:0].
  function automatic logic [39:0] base85_chars(input logic [31:0] value);
    logic [39:0] chars;
    logic [31:0] rest;
    logic [31:0] rem;
    rest = value;
    for (int i = 4; i >= 1; i--) begin
      rem = rest % 32'd85;
      chars[8*i +: 8] = rem[7:0] + CHAR_BANG;
      rest = rest / 32'd85;
    end
    chars[7:0] = rest[7:0] + CHAR_BANG;
    return chars;
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0]  run [9];
    int          n;
    int          tail;
    logic [31:0] word;
    logic [39:0] digs;
    n = 0;
    if (held_count == 2'd3) begin
      word = {held_bytes, b};
      if (word == 32'd0) begin
        run[n] = CHAR_Z;
        n++;
        line_col = line_col + 7'd1;
      end else begin
        digs = base85_chars(word);
        for (int k = 0; k < 5; k++) begin
          run[n] = digs[8*k +: 8];
          n++;
        end
        line_col = line_col + 7'd5;
      end
      // The line check only follows a whole group.
      if (line_col >= LINE_LIMIT) begin
        run[n] = CHAR_NL;
        n++;
        line_col = '0;
      end
      held_bytes = '0;
      held_count = '0;
    end else begin
      held_bytes = {held_bytes[15:0], b};
      held_count = held_count + 2'd1;
    end
    if (fin) begin
      // A partial tail is zero padded and gives n+1 digits, never 'z'.
      if (held_count != 2'd0) begin
        tail = int'(held_count);
        word = {held_bytes, 8'h00} << (8 * (3 - tail));
        digs = base85_chars(word);
        for (int k = 0; k <= tail; k++) begin
          run[n] = digs[8*k +: 8];
          n++;
        end
      end
      run[n] = CHAR_TILDE;
      run[n+1] = CHAR_GT;
      run[n+2] = CHAR_NL;
      n += 3;
      held_bytes = '0;
      held_count = '0;
      line_col = '0;
    end
    for (int k = 0; k < n; k++)
      expected_chars.push_back('{ch: run[k], last: (k == n - 1)});
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_bytes = '0;
      held_count = '0;
      line_col = '0;
    end else begin
      // Outputs are popped first: a result never belongs to the byte taken
      // at the same edge.
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          err_count++;
          $error("unexpected character 0x%h with last_of_run %b", m_tdata, m_tlast);
        end else begin
          oldest = expected_chars.pop_front();
          checked++;
          if (m_tdata !== oldest.ch) begin
            err_count++;
            $error("out_char: expected 0x%h, got 0x%h", oldest.ch, m_tdata);
          end
          if (m_tlast !== oldest.last) begin
            err_count++;
            $error("last_of_run: expected %b, got %b", oldest.last, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready)
        encode_byte(s_tdata, s_tlast);
    end
    mismatches <= err_count;
    outstanding <= expected_chars.size();
    chars_checked <= checked;
  end

endmodule

// File: tb/sv/tb_ascii85_stream_encoder_top.sv
// Testbench top for the ASCII85 stream encoder: clock, reset, byte stimulus
// and a stalling sink. Checking is done by a85_stream_checker.
// Depends on rtl/a85_pkg.sv, rtl/ascii85_stream_encoder_top.sv and the checker.
module tb_ascii85_stream_encoder_top;

  localparam int LINE_LIMIT = 75;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  int mismatches;
  int outstanding;
  int chars_checked;

  // idle_on enables random bursts of idling on both sides; quiet switches
  // all idling off for the closing stretch of the run.
  logic idle_on;
  logic quiet;
  int   sink_hold = 0;
  int   bytes_sent = 0;
  int   frames_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ascii85_stream_encoder_top #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  a85_stream_checker #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .chars_checked(chars_checked)
  );

  // The sink drops tready for bursts of random length. A burst starts
  // on about one cycle in six while idling is enabled.
  always @(posedge clk) begin
    if (quiet || !idle_on) begin
      m_tready <= 1'b1;
    end else if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      sink_hold <= $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offer one byte and wait until the encoder takes it. Before the byte the
  // sender may go idle for a short burst; the data lines carry junk then.
  task automatic send_byte(input logic [7:0] value, input logic fin);
    if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'($urandom);
      s_tlast <= 1'($urandom);
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    if (fin)
      frames_sent++;
  endtask

  // Hold the input idle until every predicted character has come out.
  task automatic drain_output();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int         random_bytes;
    int         frame_no;
    int         len;
    int         mode;
    logic [7:0] b;

    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= 8'h00;
    s_tlast <= 1'b0;
    idle_on <= 1'b1;
    quiet <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. One frame carries an all-zero group ('z'), an all-ones
    // group and a final byte that closes a full group, so the terminator
    // follows the group digits directly.
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b1);
    // All-zero group that is also the final byte.
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // Partial tails of one, two and three bytes; the zero tail must give
    // digits rather than the 'z' shortcut.
    send_byte(8'hAB, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    drain_output();

    // Random part: six well-formed frames of random length and content.
    // Frame two is fifteen dense groups, so its final byte closes a group
    // that also hits the line limit and brings the longest burst of
    // characters. Frame five is long and mixed with zero groups, so the
    // column passes the limit at varying offsets before the newline; it
    // closes the run with no idling on either side.
    random_bytes = 0;
    frame_no = 0;
    while (random_bytes < 120) begin
      if (frame_no >= 5)
        quiet <= 1'b1;
      idle_on <= ($urandom_range(0, 2) != 0);
      mode = $urandom_range(0, 2);
      len = $urandom_range(1, 8);
      if (frame_no == 2) begin
        len = 60;
        mode = 0;
      end
      if (frame_no == 5) begin
        len = $urandom_range(60, 72);
        mode = 1;
      end
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: b = ($urandom_range(0, 15) == 0) ? 8'hFF : 8'($urandom);
          1: b = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom);
          default: b = ($urandom_range(0, 7) != 0) ? 8'h00 : 8'($urandom);
        endcase
        send_byte(b, i == len - 1);
      end
      random_bytes += len;
      frame_no++;
      if ($urandom_range(0, 3) == 0)
        drain_output();
    end

    // Let everything drain, then allow for the converter and queue latency
    // so a stray extra character would still be caught.
    drain_output();
    repeat (30) @(posedge clk);
    if (outstanding != 0)
      $error("%0d expected characters never arrived", outstanding);

    $display("run covered %0d bytes in %0d frames: zero groups, tails, line breaks, stalls",
             bytes_sent, frames_sent);
    $display("%0d output characters were compared against the prediction", chars_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, including every stall.
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/a85_pkg.sv
rtl/a85_front.sv
rtl/a85_fifo.sv
rtl/a85_conv.sv
rtl/a85_emit.sv
rtl/ascii85_stream_encoder_top.sv
tb/sv/a85_stream_checker.sv
tb/sv/tb_ascii85_stream_encoder_top.sv
